// ===== hw/rtl/dvol_pkg.sv =====
// Shared types and constants for the distinct-value ordered list.
`timescale 1ns / 1ps

package dvol_pkg;

   // Number of cells in the store.
   localparam int CAPACITY = 16;

   // Width of one held value and of the occupancy counter.
   localparam int VALUE_W = 32;
   localparam int OCC_W   = $clog2(CAPACITY + 1);
   localparam int COUNT_W = 5;

   // Reverse alignment shifts by powers of two, one bit of the amount per cycle.
   localparam int SHIFT_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int STEP_W  = (SHIFT_W > 1) ? $clog2(SHIFT_W) : 1;

   // Operation codes of a request word.
   typedef enum logic [1:0] {
      OP_INSERT  = 2'd0,
      OP_REMOVE  = 2'd1,
      OP_LOOKUP  = 2'd2,
      OP_REVERSE = 2'd3
   } op_type;

   // Request word.
   typedef struct packed {
      op_type                     operation;
      logic signed [VALUE_W-1:0]  value;
   } req_type;

   // Response word.
   typedef struct packed {
      logic               success;
      logic [COUNT_W-1:0] count;
   } rsp_type;

   // Controller states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_ALIGN,
      ST_FINISH
   } state_type;

   // Datapath commands.
   typedef enum logic [2:0] {
      CMD_NONE,
      CMD_LOAD,
      CMD_COMMIT,
      CMD_MIRROR,
      CMD_ALIGN
   } cmd_kind_type;

   // Command bundle from controller to datapath.
   typedef struct packed {
      cmd_kind_type      kind;
      logic [STEP_W-1:0] step;
   } cmd_type;

   // Status bundle from datapath to controller.
   typedef struct packed {
      logic rev_multi;
      logic slot_free;
   } status_type;

endpackage

// ===== hw/rtl/dvol_datapath.sv =====
// Datapath of the distinct-value ordered list: cells, compare, shift and response register.
`timescale 1ns / 1ps

module dvol_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  dvol_pkg::cmd_type    cmd,
   output dvol_pkg::status_type status,
   input  dvol_pkg::req_type    req_data,
   input  logic                 rsp_stall,
   output logic                 rsp_valid,
   output dvol_pkg::rsp_type    rsp_data
);

   logic signed [dvol_pkg::VALUE_W-1:0] entries_ff [dvol_pkg::CAPACITY];
   logic signed [dvol_pkg::VALUE_W-1:0] entries_in [dvol_pkg::CAPACITY];
   logic [dvol_pkg::OCC_W-1:0]          occ_ff;
   logic [dvol_pkg::OCC_W-1:0]          occ_in;
   dvol_pkg::op_type                    op_ff;
   dvol_pkg::op_type                    op_in;
   logic signed [dvol_pkg::VALUE_W-1:0] value_ff;
   logic signed [dvol_pkg::VALUE_W-1:0] value_in;
   logic [dvol_pkg::SHIFT_W-1:0]        shift_ff;
   logic [dvol_pkg::SHIFT_W-1:0]        shift_in;
   logic                                rsp_valid_ff;
   logic                                rsp_valid_in;
   dvol_pkg::rsp_type                   rsp_data_ff;
   dvol_pkg::rsp_type                   rsp_data_in;

   logic [dvol_pkg::CAPACITY-1:0]       hit;
   logic [dvol_pkg::CAPACITY-1:0]       at_or_after_hit;
   logic                                found;
   logic                                full;
   logic                                commit_ok;
   logic signed [dvol_pkg::VALUE_W-1:0] next_val  [dvol_pkg::CAPACITY];
   logic signed [dvol_pkg::VALUE_W-1:0] cand      [dvol_pkg::CAPACITY][dvol_pkg::SHIFT_W];
   logic signed [dvol_pkg::VALUE_W-1:0] align_val [dvol_pkg::CAPACITY];

   // Compare the held value against every occupied cell at once.
   always_comb begin
      for (int i = 0; i < dvol_pkg::CAPACITY; i++) begin
         hit[i] = (dvol_pkg::OCC_W'(i) < occ_ff) && (entries_ff[i] == value_ff);
      end
   end

   assign found = |hit;
   assign full  = (occ_ff >= dvol_pkg::OCC_W'(dvol_pkg::CAPACITY));

   // Per-cell neighbour taps: the next cell for removal, and the cells at
   // power-of-two distances for reverse alignment.
   for (genvar i = 0; i < dvol_pkg::CAPACITY; i++) begin : g_cell
      assign at_or_after_hit[i] = |hit[i:0];

      if (i + 1 < dvol_pkg::CAPACITY) begin : g_next
         assign next_val[i] = entries_ff[i+1];
      end else begin : g_last
         assign next_val[i] = entries_ff[i];
      end

      for (genvar k = 0; k < dvol_pkg::SHIFT_W; k++) begin : g_dist
         if (i + (2 ** k) < dvol_pkg::CAPACITY) begin : g_in_range
            assign cand[i][k] = entries_ff[i + (2 ** k)];
         end else begin : g_out_range
            assign cand[i][k] = entries_ff[i];
         end
      end
   end

   // Alignment picks the tap for the current bit of the shift amount.
   always_comb begin
      for (int i = 0; i < dvol_pkg::CAPACITY; i++) begin
         align_val[i] = entries_ff[i];
         for (int k = 0; k < dvol_pkg::SHIFT_W; k++) begin
            if ((cmd.step == dvol_pkg::STEP_W'(k)) && shift_ff[k]) begin
               align_val[i] = cand[i][k];
            end
         end
      end
   end

   // Capture the request word on acceptance.
   always_comb begin
      op_in    = op_ff;
      value_in = value_ff;
      if (cmd.kind == dvol_pkg::CMD_LOAD) begin
         op_in    = req_data.operation;
         value_in = req_data.value;
      end
   end

   // Cell, occupancy and response updates under the current command.
   always_comb begin
      entries_in   = entries_ff;
      occ_in       = occ_ff;
      shift_in     = shift_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      commit_ok    = 1'b0;
      unique case (cmd.kind)
         dvol_pkg::CMD_COMMIT: begin
            unique case (op_ff)
               dvol_pkg::OP_INSERT: begin
                  if (!found && !full) begin
                     commit_ok = 1'b1;
                     occ_in    = occ_ff + dvol_pkg::OCC_W'(1);
                     for (int i = 0; i < dvol_pkg::CAPACITY; i++) begin
                        if (dvol_pkg::OCC_W'(i) == occ_ff) begin
                           entries_in[i] = value_ff;
                        end
                     end
                  end
               end
               dvol_pkg::OP_REMOVE: begin
                  if (found) begin
                     commit_ok = 1'b1;
                     occ_in    = occ_ff - dvol_pkg::OCC_W'(1);
                     for (int i = 0; i < dvol_pkg::CAPACITY; i++) begin
                        if (at_or_after_hit[i]) begin
                           entries_in[i] = next_val[i];
                        end
                     end
                  end
               end
               dvol_pkg::OP_LOOKUP: begin
                  commit_ok = found;
               end
               dvol_pkg::OP_REVERSE: begin
                  commit_ok = 1'b1;
               end
            endcase
            rsp_valid_in        = 1'b1;
            rsp_data_in.success = commit_ok;
            rsp_data_in.count   = dvol_pkg::COUNT_W'(occ_in);
         end
         dvol_pkg::CMD_MIRROR: begin
            // Mirror the whole store; the live entries then sit at the top end.
            for (int i = 0; i < dvol_pkg::CAPACITY; i++) begin
               entries_in[i] = entries_ff[dvol_pkg::CAPACITY-1-i];
            end
            shift_in = dvol_pkg::SHIFT_W'(dvol_pkg::OCC_W'(dvol_pkg::CAPACITY) - occ_ff);
         end
         dvol_pkg::CMD_ALIGN: begin
            entries_in = align_val;
         end
         default: begin
         end
      endcase
   end

   // Cells hold no reset value; only occupied cells are compared.
   always_ff @(posedge clock) begin
      entries_ff  <= entries_in;
      op_ff       <= op_in;
      value_ff    <= value_in;
      shift_ff    <= shift_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign status.rev_multi = (op_ff == dvol_pkg::OP_REVERSE) && (occ_ff > dvol_pkg::OCC_W'(1));
   assign status.slot_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_data         = rsp_data_ff;

`ifndef SYNTHESIS
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= dvol_pkg::OCC_W'(dvol_pkg::CAPACITY))
      else $error("occupancy above capacity");

   // Mid-reverse the low cells are in transit, so distinctness holds at commit.
   a_hit_unique: assert property (@(posedge clock) disable iff (reset)
      (cmd.kind == dvol_pkg::CMD_COMMIT) |-> $onehot0(hit))
      else $error("value held in more than one cell");

   a_occ_hold: assert property (@(posedge clock) disable iff (reset)
      (cmd.kind != dvol_pkg::CMD_COMMIT) |=> $stable(occ_ff))
      else $error("occupancy changed without a commit");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.kind == dvol_pkg::CMD_COMMIT) |-> status.slot_free)
      else $error("commit onto a stalled response");
`endif

endmodule

// ===== hw/rtl/dvol_controller.sv =====
// Controller state machine of the distinct-value ordered list.
`timescale 1ns / 1ps

module dvol_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  dvol_pkg::status_type status,
   output dvol_pkg::cmd_type    cmd
);

   dvol_pkg::state_type      state_ff;
   dvol_pkg::state_type      state_in;
   logic [dvol_pkg::STEP_W-1:0] step_ff;
   logic [dvol_pkg::STEP_W-1:0] step_in;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dvol_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = dvol_pkg::ST_EXEC;
            end
         end
         dvol_pkg::ST_EXEC: begin
            if (status.rev_multi) begin
               state_in = dvol_pkg::ST_ALIGN;
            end else if (status.slot_free) begin
               state_in = dvol_pkg::ST_IDLE;
            end
         end
         dvol_pkg::ST_ALIGN: begin
            if (step_ff == '0) begin
               state_in = dvol_pkg::ST_FINISH;
            end
         end
         dvol_pkg::ST_FINISH: begin
            if (status.slot_free) begin
               state_in = dvol_pkg::ST_IDLE;
            end
         end
      endcase
   end

   // Shift step counter runs from the top bit of the amount down to bit zero.
   always_comb begin
      step_in = step_ff;
      if ((state_ff == dvol_pkg::ST_EXEC) && status.rev_multi) begin
         step_in = dvol_pkg::STEP_W'(dvol_pkg::SHIFT_W - 1);
      end else if ((state_ff == dvol_pkg::ST_ALIGN) && (step_ff != '0)) begin
         step_in = step_ff - dvol_pkg::STEP_W'(1);
      end
   end

   // Outputs: commands to the datapath and the request stall.
   always_comb begin
      cmd.kind  = dvol_pkg::CMD_NONE;
      cmd.step  = step_ff;
      req_stall = (state_ff != dvol_pkg::ST_IDLE);
      unique case (state_ff)
         dvol_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd.kind = dvol_pkg::CMD_LOAD;
            end
         end
         dvol_pkg::ST_EXEC: begin
            if (status.rev_multi) begin
               cmd.kind = dvol_pkg::CMD_MIRROR;
            end else if (status.slot_free) begin
               cmd.kind = dvol_pkg::CMD_COMMIT;
            end
         end
         dvol_pkg::ST_ALIGN: begin
            cmd.kind = dvol_pkg::CMD_ALIGN;
         end
         dvol_pkg::ST_FINISH: begin
            if (status.slot_free) begin
               cmd.kind = dvol_pkg::CMD_COMMIT;
            end
         end
      endcase
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dvol_pkg::ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

`ifndef SYNTHESIS
   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == dvol_pkg::ST_EXEC))
      else $error("accepted word not executed");

   a_align_start: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == dvol_pkg::ST_EXEC) && status.rev_multi) |=>
      ((state_ff == dvol_pkg::ST_ALIGN) &&
       (step_ff == dvol_pkg::STEP_W'(dvol_pkg::SHIFT_W - 1))))
      else $error("alignment did not start at the top step");

   a_align_end: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == dvol_pkg::ST_ALIGN) && (step_ff == '0)) |=>
      (state_ff == dvol_pkg::ST_FINISH))
      else $error("alignment did not finish after the last step");
`endif

endmodule

// ===== hw/rtl/distinct_value_ordered_list.sv =====
// Top level of the distinct-value ordered list.
`timescale 1ns / 1ps

// Ordered store of up to sixteen distinct signed 32-bit values.
// Request channel (req_): one word carries an operation (insert, remove,
// lookup, reverse) and a value. It is taken when req_valid is high and
// req_stall is low; req_stall is low only while the block is idle.
// Response channel (rsp_): one word per request with a success flag and the
// count held after the request, presented from an output register.
// Insert, remove and lookup first accept the word, then compare the value
// against all cells and update them; the response appears in the cycle
// after that update.
// Reverse of two or more entries mirrors the store, then realigns it with
// one power-of-two shift per bit of the shift amount before it commits.
// While the receiver stalls a response, the next request is still accepted;
// its commit waits until the held response is taken.
// Reset empties the store and clears the response valid flag.
module distinct_value_ordered_list (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  dvol_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output dvol_pkg::rsp_type rsp_data
);

   dvol_pkg::cmd_type    cmd;
   dvol_pkg::status_type status;

   // Sequencing.
   dvol_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Storage, compare and response.
   dvol_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_data  (req_data),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule
